[rtl/core/wper_pkg.sv]
// ----------------------------------------------------------------------------
// Waveform peak envelope package
// Shared constants, command and register codes, and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package wper_pkg;

    // Input command codes. Code 3 carries no meaning and is ignored.
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_FLUSH  = 2'd1;
    localparam logic [1:0] CMD_START  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_ROW_ADVANCE    = 3'd0;
    localparam logic [2:0] REG_SAMPLE_SKIP    = 3'd1;
    localparam logic [2:0] REG_HALF_WIDTH     = 3'd2;
    localparam logic [2:0] REG_LUM_SCALE      = 3'd3;
    localparam logic [2:0] REG_LUM_MODE       = 3'd4;
    localparam logic [2:0] REG_SHAPE_MODE     = 3'd5;
    localparam logic [2:0] REG_ROWS_PER_BLOCK = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Limits on the row count and the edge magnitude.
    localparam logic [9:0]  MAX_ROWS       = 10'd512;
    localparam logic [10:0] MAX_HALF_WIDTH = 11'd2047;

    // One sample per row in unsigned 16.16.
    localparam logic [31:0] ADVANCE_ONE = 32'h0001_0000;

    // Reset values of the configuration registers.
    localparam logic [31:0] ROW_ADVANCE_RST    = 32'h0001_0000;
    localparam logic [15:0] SAMPLE_SKIP_RST    = 16'd1;
    localparam logic [10:0] HALF_WIDTH_RST     = 11'd255;
    localparam logic [23:0] LUM_SCALE_RST      = 24'd65280;
    localparam logic [9:0]  ROWS_PER_BLOCK_RST = 10'd128;

    // Empty-row values of the running minimum and maximum.
    localparam logic signed [15:0] ROW_MIN_INIT = 16'sh7FFF;
    localparam logic signed [15:0] ROW_MAX_INIT = 16'sh8000;

    localparam logic [7:0] LUM_FULL = 8'd255;

    // Controller to datapath.
    typedef struct packed {
        logic item_load;
        logic start;
        logic mul_en;
        logic edge_en;
        logic lum_en;
        logic emit;
        logic fold;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic [1:0] cmd;
        logic       need_close;
        logic       done;
        logic       last_row;
        logic       out_busy;
    } dp_status_t;

endpackage

[rtl/core/waveform_peak_envelope_rows.sv]
// ----------------------------------------------------------------------------
// Waveform peak envelope rows
// Min/max peak decimation of a block of audio into pixel rows.
// ----------------------------------------------------------------------------
// Signed 16-bit samples stream in with command 0; every sample_skip-th sample
// of the block is folded into the running min and max of the current pixel
// row, and a row is closed when the sample count reaches its 32.16 end.
// Command 1 closes the pending row, command 2 starts a new block. Each closed
// row leaves as one output transaction with its scaled edges, span and
// luminance. Transactions are taken one at a time: a sample that closes no
// row, a start or an ignored command passes the accept and decode stages;
// a row close (a flush or a sample crossing a row end) passes through the
// accept, decode, scaling multiply, edge, luminance multiply and output
// stages, and waits in the output stage while the previous row still sits
// stalled in the output register. The configuration port is always ready;
// the user writes it between transactions; the block does not enforce this.
module waveform_peak_envelope_rows
    import wper_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             command,
    input  logic signed [15:0]     sample,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [8:0]             row_number,
    output logic signed [11:0]     edge_left,
    output logic signed [11:0]     edge_right,
    output logic [12:0]            span_start,
    output logic [12:0]            span_end,
    output logic [7:0]             luminance,
    output logic                   last_row
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    wper_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    wper_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .command    (command),
        .sample     (sample),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .row_number (row_number),
        .edge_left  (edge_left),
        .edge_right (edge_right),
        .span_start (span_start),
        .span_end   (span_end),
        .luminance  (luminance),
        .last_row   (last_row),
        .dp_cmd     (dp_cmd),
        .dp_status  (dp_status)
    );

endmodule

[rtl/core/wper_ctrl.sv]
// ----------------------------------------------------------------------------
// Waveform peak envelope controller
// Sequences one input transaction at a time: decode, the three row-close
// stages, and the hand-off of a closed row to the output register.
// ----------------------------------------------------------------------------
module wper_ctrl
    import wper_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t dp_status,
    output dp_cmd_t    dp_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DECIDE = 6'b000010,
        ST_MUL    = 6'b000100,
        ST_EDGE   = 6'b001000,
        ST_LUM    = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        dp_cmd.item_load = in_valid && !in_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_IDLE;
                case (dp_status.cmd)
                    CMD_START:
                    begin
                        dp_cmd.start = 1'b1;
                    end
                    CMD_FLUSH:
                    begin
                        if (!dp_status.done)
                        begin
                            state_next = ST_MUL;
                        end
                    end
                    CMD_SAMPLE:
                    begin
                        if (!dp_status.done)
                        begin
                            if (dp_status.need_close)
                            begin
                                state_next = ST_MUL;
                            end
                            else
                            begin
                                dp_cmd.fold = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_MUL:
            begin
                dp_cmd.mul_en = 1'b1;
                state_next    = ST_EDGE;
            end
            ST_EDGE:
            begin
                dp_cmd.edge_en = 1'b1;
                state_next     = ST_LUM;
            end
            ST_LUM:
            begin
                dp_cmd.lum_en = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!dp_status.out_busy)
                begin
                    dp_cmd.emit = 1'b1;
                    // The sample goes into the next row unless that row is past the block.
                    dp_cmd.fold = (dp_status.cmd == CMD_SAMPLE) && !dp_status.last_row;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_decide_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE) |-> $past(in_valid && !in_stall))
        else $error("decode state entered without an accepted transaction");

    a_emit_after_lum: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.emit |-> ($past(state_reg) == ST_LUM || $past(state_reg) == ST_EMIT))
        else $error("row emitted without passing the close stages");

    a_mul_then_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |=> (state_reg == ST_EDGE))
        else $error("multiply stage not followed by edge stage");

endmodule

[rtl/core/wper_dp.sv]
// ----------------------------------------------------------------------------
// Waveform peak envelope datapath
// Configuration registers, row state, the scaling and luminance multipliers
// and the output register.
// ----------------------------------------------------------------------------
module wper_dp
    import wper_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [1:0]             command,
    input  logic signed [15:0]     sample,
    input  logic                   out_stall,
    output logic                   out_valid,
    output logic [8:0]             row_number,
    output logic signed [11:0]     edge_left,
    output logic signed [11:0]     edge_right,
    output logic [12:0]            span_start,
    output logic [12:0]            span_end,
    output logic [7:0]             luminance,
    output logic                   last_row,
    input  dp_cmd_t                dp_cmd,
    output dp_status_t             dp_status
);

    // Configuration.
    logic [31:0] row_advance_reg;
    logic [15:0] sample_skip_reg;
    logic [10:0] half_width_reg;
    logic [23:0] lum_scale_reg;
    logic        lum_mode_reg;
    logic        shape_mode_reg;
    logic [9:0]  rows_per_block_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_advance_reg    <= ROW_ADVANCE_RST;
            sample_skip_reg    <= SAMPLE_SKIP_RST;
            half_width_reg     <= HALF_WIDTH_RST;
            lum_scale_reg      <= LUM_SCALE_RST;
            lum_mode_reg       <= 1'b0;
            shape_mode_reg     <= 1'b0;
            rows_per_block_reg <= ROWS_PER_BLOCK_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ROW_ADVANCE:    row_advance_reg    <= cfg_data[31:0];
                REG_SAMPLE_SKIP:    sample_skip_reg    <= cfg_data[15:0];
                REG_HALF_WIDTH:     half_width_reg     <= cfg_data[10:0];
                REG_LUM_SCALE:      lum_scale_reg      <= cfg_data[23:0];
                REG_LUM_MODE:       lum_mode_reg       <= cfg_data[0];
                REG_SHAPE_MODE:     shape_mode_reg     <= cfg_data[0];
                REG_ROWS_PER_BLOCK: rows_per_block_reg <= cfg_data[9:0];
                default:            ;
            endcase
        end
    end

    logic [31:0] eff_advance;
    logic [9:0]  eff_rows;
    logic [15:0] eff_skip;
    logic [10:0] wh;

    assign eff_advance = (row_advance_reg < ADVANCE_ONE) ? ADVANCE_ONE : row_advance_reg;
    assign eff_rows    = (rows_per_block_reg > MAX_ROWS) ? MAX_ROWS : rows_per_block_reg;
    assign eff_skip    = (sample_skip_reg == 16'd0) ? 16'd1 : sample_skip_reg;
    assign wh          = (half_width_reg > MAX_HALF_WIDTH) ? MAX_HALF_WIDTH : half_width_reg;

    // Held transaction.
    logic [1:0]         cmd_reg;
    logic signed [15:0] sample_reg;

    always_ff @(posedge clk)
    begin
        if (dp_cmd.item_load)
        begin
            cmd_reg    <= command;
            sample_reg <= sample;
        end
    end

    // Row state.
    logic [9:0]         row_counter_reg,   row_counter_next;
    logic [31:0]        sample_offset_reg, sample_offset_next;
    logic [47:0]        row_boundary_reg,  row_boundary_next;
    logic [15:0]        skip_counter_reg,  skip_counter_next;
    logic signed [15:0] running_min_reg,   running_min_next;
    logic signed [15:0] running_max_reg,   running_max_next;
    logic signed [15:0] base_min;
    logic signed [15:0] base_max;
    logic [16:0]        skip_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_counter_reg   <= '0;
            sample_offset_reg <= '0;
            row_boundary_reg  <= {16'd0, ADVANCE_ONE};
            skip_counter_reg  <= '0;
            running_min_reg   <= ROW_MIN_INIT;
            running_max_reg   <= ROW_MAX_INIT;
        end
        else
        begin
            row_counter_reg   <= row_counter_next;
            sample_offset_reg <= sample_offset_next;
            row_boundary_reg  <= row_boundary_next;
            skip_counter_reg  <= skip_counter_next;
            running_min_reg   <= running_min_next;
            running_max_reg   <= running_max_next;
        end
    end

    assign skip_inc = {1'b0, skip_counter_reg} + 17'd1;

    always_comb
    begin
        row_counter_next   = row_counter_reg;
        sample_offset_next = sample_offset_reg;
        row_boundary_next  = row_boundary_reg;
        skip_counter_next  = skip_counter_reg;
        running_min_next   = running_min_reg;
        running_max_next   = running_max_reg;
        base_min           = running_min_reg;
        base_max           = running_max_reg;
        if (dp_cmd.start)
        begin
            row_counter_next   = '0;
            sample_offset_next = '0;
            row_boundary_next  = {16'd0, eff_advance};
            skip_counter_next  = '0;
            running_min_next   = ROW_MIN_INIT;
            running_max_next   = ROW_MAX_INIT;
        end
        else
        begin
            if (dp_cmd.emit)
            begin
                row_counter_next  = row_counter_reg + 10'd1;
                row_boundary_next = row_boundary_reg + {16'd0, eff_advance};
                base_min          = ROW_MIN_INIT;
                base_max          = ROW_MAX_INIT;
                running_min_next  = ROW_MIN_INIT;
                running_max_next  = ROW_MAX_INIT;
            end
            if (dp_cmd.fold)
            begin
                // A closing sample folds into the freshly cleared row.
                if (skip_counter_reg == 16'd0)
                begin
                    running_min_next = (sample_reg < base_min) ? sample_reg : base_min;
                    running_max_next = (sample_reg > base_max) ? sample_reg : base_max;
                end
                skip_counter_next  = (skip_inc >= {1'b0, eff_skip}) ? 16'd0 : skip_inc[15:0];
                sample_offset_next = sample_offset_reg + 32'd1;
            end
        end
    end

    // Row close, stage 1: scale min and max by half_width.
    logic signed [11:0] wh_s;
    logic signed [27:0] prod_min_reg;
    logic signed [27:0] prod_max_reg;

    assign wh_s = {1'b0, wh};

    always_ff @(posedge clk)
    begin
        if (dp_cmd.mul_en)
        begin
            prod_min_reg <= 28'(running_min_reg) * 28'(wh_s);
            prod_max_reg <= 28'(running_max_reg) * 28'(wh_s);
        end
    end

    // Stage 2: floor by 2^15, clamp, empty-row test and magnitude.
    logic signed [12:0] l_raw;
    logic signed [12:0] r_raw;
    logic signed [12:0] wh13;
    logic signed [12:0] l_clamp;
    logic signed [12:0] r_clamp;
    logic signed [11:0] l_edge;
    logic signed [11:0] r_edge;
    logic [11:0]        l_abs;
    logic [11:0]        r_abs;
    logic signed [11:0] l_reg;
    logic signed [11:0] r_reg;
    logic [10:0]        mag_reg;

    // The top bits of the product are the floor of the quotient by 2^15.
    assign l_raw = prod_min_reg[27:15];
    assign r_raw = prod_max_reg[27:15];
    assign wh13  = {2'b00, wh};

    always_comb
    begin
        l_clamp = (l_raw < -wh13) ? -wh13 : ((l_raw > wh13) ? wh13 : l_raw);
        r_clamp = (r_raw < -wh13) ? -wh13 : ((r_raw > wh13) ? wh13 : r_raw);
        if (r_raw > l_raw)
        begin
            l_edge = l_clamp[11:0];
            r_edge = r_clamp[11:0];
        end
        else
        begin
            l_edge = '0;
            r_edge = '0;
        end
        l_abs = l_edge[11] ? 12'(-l_edge) : 12'(l_edge);
        r_abs = r_edge[11] ? 12'(-r_edge) : 12'(r_edge);
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.edge_en)
        begin
            l_reg   <= l_edge;
            r_reg   <= r_edge;
            mag_reg <= (l_abs > r_abs) ? l_abs[10:0] : r_abs[10:0];
        end
    end

    // Stage 3: amplitude luminance product.
    logic [34:0] lum_prod;
    logic [18:0] lum_q_reg;

    assign lum_prod = 35'(mag_reg) * 35'(lum_scale_reg);

    always_ff @(posedge clk)
    begin
        if (dp_cmd.lum_en)
        begin
            lum_q_reg <= lum_prod[34:16];
        end
    end

    // Emit: saturation, span and output register.
    logic [7:0]  lum_final;
    logic [12:0] cx;
    logic [12:0] l_ext;
    logic [12:0] r_ext;
    logic [12:0] span_s;
    logic [12:0] span_e;

    assign cx    = {2'b00, wh} + 13'd1;
    assign l_ext = {l_reg[11], l_reg};
    assign r_ext = {r_reg[11], r_reg};

    always_comb
    begin
        if (!lum_mode_reg)
        begin
            lum_final = LUM_FULL;
        end
        else if (|lum_q_reg[18:8])
        begin
            lum_final = LUM_FULL;
        end
        else
        begin
            lum_final = lum_q_reg[7:0];
        end
        if (shape_mode_reg)
        begin
            span_s = cx + (l_reg[11] ? l_ext : 13'd0);
            span_e = cx + ((r_reg > 12'sd0) ? r_ext : 13'd0);
        end
        else
        begin
            span_s = cx - {2'b00, mag_reg};
            span_e = cx + {2'b00, mag_reg};
        end
    end

    logic out_valid_reg;
    logic is_last;

    assign is_last = ((row_counter_reg + 10'd1) == eff_rows);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (dp_cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.emit)
        begin
            row_number <= row_counter_reg[8:0];
            edge_left  <= l_reg;
            edge_right <= r_reg;
            span_start <= span_s;
            span_end   <= span_e;
            luminance  <= lum_final;
            last_row   <= is_last;
        end
    end

    assign out_valid = out_valid_reg;

    assign dp_status.cmd        = cmd_reg;
    assign dp_status.need_close = (sample_offset_reg >= row_boundary_reg[47:16]);
    assign dp_status.done       = (row_counter_reg >= eff_rows);
    assign dp_status.last_row   = is_last;
    assign dp_status.out_busy   = out_valid_reg && out_stall;

    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(dp_cmd.emit))
        else $error("output transaction raised without a row close");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.start |=> (row_counter_reg == 10'd0 && skip_counter_reg == 16'd0))
        else $error("start command did not clear the row state");

endmodule
